### sv/assert_macros.svh
// Assertion macros shared by the complex arithmetic unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define CAU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define CAU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/cau_pkg.sv
// Types, constants and helper functions of the complex arithmetic unit.
package cau_pkg;

	// Operand and result widths.
	localparam int OPW     = 16;
	localparam int FRAC_IN = 8;
	localparam int FRAC_SH = 16;
	localparam int RW      = 32;
	localparam int PW      = 2 * OPW;
	localparam int SW      = PW + 1;
	localparam int DW      = PW;
	localparam int QW      = RW;
	localparam int QMW     = QW + 1;

	// Divider layout: quotient bits retired per stage and stage count.
	localparam int DIV_BPS    = 2;
	localparam int DIV_STAGES = QW / DIV_BPS;
	localparam int NST        = 3 + 1 + DIV_STAGES + 1;

	typedef enum logic [1:0] {
		OP_ADD = 2'd0,
		OP_SUB = 2'd1,
		OP_MUL = 2'd2,
		OP_DIV = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK  = 2'd0,
		ST_DZ  = 2'd1,
		ST_SAT = 2'd2
	} status_t;

	typedef struct packed {
		logic [1:0]            req_type;
		logic signed [OPW-1:0] a_re;
		logic signed [OPW-1:0] a_im;
		logic signed [OPW-1:0] b_re;
		logic signed [OPW-1:0] b_im;
	} req_beat_t;

	typedef struct packed {
		logic signed [RW-1:0] res_re;
		logic signed [RW-1:0] res_im;
		status_t              status;
	} rsp_beat_t;

	// Sideband that follows an item down the pipeline.
	typedef struct packed {
		op_t  op;
		logic neg_re;
		logic neg_im;
		logic dz;
	} ctl_t;

	// One restoring division step: returns {quotient bit, new remainder}.
	function automatic logic [DW:0] div_step(logic [DW-1:0] r, logic b, logic [DW-1:0] d);
		logic [DW:0] t;
		logic        qb;
		t  = {r, b};
		qb = 1'b0;
		if (t >= {1'b0, d}) begin
			t  = t - {1'b0, d};
			qb = 1'b1;
		end
		return {qb, t[DW-1:0]};
	endfunction

	// Clamps a sign and magnitude to a 32-bit two's-complement value: {sat, value}.
	function automatic logic [RW:0] pack_sat(logic neg, logic [QMW-1:0] mag);
		logic [QMW-1:0] pos_lim;
		logic [QMW-1:0] neg_lim;
		logic [QMW-1:0] m;
		logic           sat;
		pos_lim = {2'b00, {(QMW-2){1'b1}}};
		neg_lim = {2'b01, {(QMW-2){1'b0}}};
		m       = mag;
		sat     = 1'b0;
		if (neg) begin
			if (mag > neg_lim) begin
				m   = neg_lim;
				sat = 1'b1;
			end
			return {sat, RW'(-m)};
		end
		if (mag > pos_lim) begin
			m   = pos_lim;
			sat = 1'b1;
		end
		return {sat, m[RW-1:0]};
	endfunction

endpackage

### sv/cau_front.sv
// Front end: products, sums and sign/magnitude split over three stages.
module cau_front (
	input  logic                      clk,
	input  logic [2:0]                adv,
	input  cau_pkg::req_beat_t        req_data,
	output logic [cau_pkg::DW-1:0]    mag_re,
	output logic [cau_pkg::DW-1:0]    mag_im,
	output logic [cau_pkg::DW-1:0]    den,
	output cau_pkg::ctl_t             ctl
);

	cau_pkg::op_t                     op_s1, op_s2, op_s3;
	logic signed [cau_pkg::PW-1:0]    ac_s1, bd_s1, ad_s1, bc_s1, cc_s1, dd_s1;
	logic signed [cau_pkg::OPW:0]     asr_s1, asi_s1;
	logic signed [cau_pkg::SW-1:0]    re_s2, im_s2;
	logic [cau_pkg::DW-1:0]           den_s2, den_s3;
	logic [cau_pkg::DW-1:0]           mre_s3, mim_s3;
	logic                             nre_s3, nim_s3, dz_s3;
	logic signed [cau_pkg::SW-1:0]    re_c, im_c;
	cau_pkg::op_t                     op_in;

	assign op_in = cau_pkg::op_t'(req_data.req_type);

	// Stage 1: all partial products and the short sums.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			op_s1  <= op_in;
			ac_s1  <= req_data.a_re * req_data.b_re;
			bd_s1  <= req_data.a_im * req_data.b_im;
			ad_s1  <= req_data.a_re * req_data.b_im;
			bc_s1  <= req_data.a_im * req_data.b_re;
			cc_s1  <= req_data.b_re * req_data.b_re;
			dd_s1  <= req_data.b_im * req_data.b_im;
			if (op_in == cau_pkg::OP_SUB) begin
				asr_s1 <= (cau_pkg::OPW+1)'(req_data.a_re) - (cau_pkg::OPW+1)'(req_data.b_re);
				asi_s1 <= (cau_pkg::OPW+1)'(req_data.a_im) - (cau_pkg::OPW+1)'(req_data.b_im);
			end else begin
				asr_s1 <= (cau_pkg::OPW+1)'(req_data.a_re) + (cau_pkg::OPW+1)'(req_data.b_re);
				asi_s1 <= (cau_pkg::OPW+1)'(req_data.a_im) + (cau_pkg::OPW+1)'(req_data.b_im);
			end
		end
	end

	// Stage 2 logic: combine products per operation.
	always_comb begin
		case (op_s1)
			cau_pkg::OP_ADD, cau_pkg::OP_SUB: begin
				re_c = cau_pkg::SW'(asr_s1) <<< cau_pkg::FRAC_IN;
				im_c = cau_pkg::SW'(asi_s1) <<< cau_pkg::FRAC_IN;
			end
			cau_pkg::OP_MUL: begin
				re_c = cau_pkg::SW'(ac_s1) - cau_pkg::SW'(bd_s1);
				im_c = cau_pkg::SW'(ad_s1) + cau_pkg::SW'(bc_s1);
			end
			default: begin
				re_c = cau_pkg::SW'(ac_s1) + cau_pkg::SW'(bd_s1);
				im_c = cau_pkg::SW'(bc_s1) - cau_pkg::SW'(ad_s1);
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			op_s2  <= op_s1;
			re_s2  <= re_c;
			im_s2  <= im_c;
			den_s2 <= cau_pkg::DW'($unsigned(cc_s1)) + cau_pkg::DW'($unsigned(dd_s1));
		end
	end

	// Stage 3: sign and magnitude, and the zero-divisor flag.
	always_ff @(posedge clk) begin
		if (adv[2]) begin
			op_s3  <= op_s2;
			nre_s3 <= re_s2[cau_pkg::SW-1];
			nim_s3 <= im_s2[cau_pkg::SW-1];
			mre_s3 <= cau_pkg::DW'(re_s2[cau_pkg::SW-1] ? -re_s2 : re_s2);
			mim_s3 <= cau_pkg::DW'(im_s2[cau_pkg::SW-1] ? -im_s2 : im_s2);
			den_s3 <= den_s2;
			dz_s3  <= (op_s2 == cau_pkg::OP_DIV) && (den_s2 == '0);
		end
	end

	assign mag_re     = mre_s3;
	assign mag_im     = mim_s3;
	assign den        = den_s3;
	assign ctl.op     = op_s3;
	assign ctl.neg_re = nre_s3;
	assign ctl.neg_im = nim_s3;
	assign ctl.dz     = dz_s3;

endmodule

### sv/cau_div.sv
// Pipelined restoring divider for one lane: floor(mag * 2^16 / den), clamped.
module cau_div (
	input  logic                               clk,
	input  logic [cau_pkg::DIV_STAGES:0]       adv,
	input  logic [cau_pkg::DW-1:0]             mag,
	input  logic [cau_pkg::DW-1:0]             den,
	output logic [cau_pkg::QMW-1:0]            quo,
	output logic [cau_pkg::DW-1:0]             mag_out
);

	localparam int N = cau_pkg::DIV_STAGES;

	logic [cau_pkg::DW-1:0] r_s   [N+1];
	logic [cau_pkg::QW-1:0] lo_s  [N+1];
	logic [cau_pkg::QW-1:0] q_s   [N+1];
	logic [cau_pkg::DW-1:0] den_s [N+1];
	logic [cau_pkg::DW-1:0] mag_s [N+1];
	logic                   ovf_s [N+1];

	logic [cau_pkg::DW-1:0] r_nx  [N+1];
	logic [cau_pkg::QW-1:0] lo_nx [N+1];
	logic [cau_pkg::QW-1:0] q_nx  [N+1];

	// Each stage retires DIV_BPS quotient bits from the previous stage.
	always_comb begin
		logic [cau_pkg::DW-1:0] r;
		logic [cau_pkg::QW-1:0] lo;
		logic [cau_pkg::QW-1:0] q;
		logic [cau_pkg::DW:0]   st;
		r_nx[0]  = '0;
		lo_nx[0] = '0;
		q_nx[0]  = '0;
		for (int k = 1; k <= N; k++) begin
			r  = r_s[k-1];
			lo = lo_s[k-1];
			q  = q_s[k-1];
			for (int j = 0; j < cau_pkg::DIV_BPS; j++) begin
				st = cau_pkg::div_step(r, lo[cau_pkg::QW-1], den_s[k-1]);
				r  = st[cau_pkg::DW-1:0];
				q  = {q[cau_pkg::QW-2:0], st[cau_pkg::DW]};
				lo = lo << 1;
			end
			r_nx[k]  = r;
			lo_nx[k] = lo;
			q_nx[k]  = q;
		end
	end

	// Entry stage: overflow check and the initial partial remainder.
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ovf_s[0] <= {{cau_pkg::FRAC_SH{1'b0}}, mag} >= {den, {cau_pkg::FRAC_SH{1'b0}}};
			r_s[0]   <= cau_pkg::DW'(mag >> cau_pkg::FRAC_SH);
			lo_s[0]  <= {mag[cau_pkg::FRAC_SH-1:0], {(cau_pkg::QW-cau_pkg::FRAC_SH){1'b0}}};
			q_s[0]   <= '0;
			den_s[0] <= den;
			mag_s[0] <= mag;
		end
	end

	// Step stages.
	always_ff @(posedge clk) begin
		for (int k = 1; k <= N; k++) begin
			if (adv[k]) begin
				r_s[k]   <= r_nx[k];
				lo_s[k]  <= lo_nx[k];
				q_s[k]   <= q_nx[k];
				den_s[k] <= den_s[k-1];
				mag_s[k] <= mag_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	// An overflowed quotient reads as 2^32, which always saturates.
	assign quo     = ovf_s[N] ? {1'b1, {cau_pkg::QW{1'b0}}} : {1'b0, q_s[N]};
	assign mag_out = mag_s[N];

endmodule

### sv/cau_out.sv
// Output stage: result selection, saturation and the output register.
module cau_out (
	input  logic                          clk,
	input  logic                          adv,
	input  cau_pkg::ctl_t                 ctl,
	input  logic [cau_pkg::QMW-1:0]       quo_re,
	input  logic [cau_pkg::QMW-1:0]       quo_im,
	input  logic [cau_pkg::DW-1:0]        mag_re,
	input  logic [cau_pkg::DW-1:0]        mag_im,
	output cau_pkg::rsp_beat_t            rsp_data
);

	logic [cau_pkg::QMW-1:0] sel_re, sel_im;
	logic [cau_pkg::RW:0]    pk_re, pk_im;
	cau_pkg::rsp_beat_t      rsp_c;
	cau_pkg::rsp_beat_t      rsp_s21;

	// Pick the quotient for a divide, the plain magnitude otherwise.
	always_comb begin
		if (ctl.op == cau_pkg::OP_DIV) begin
			sel_re = quo_re;
			sel_im = quo_im;
		end else begin
			sel_re = cau_pkg::QMW'(mag_re);
			sel_im = cau_pkg::QMW'(mag_im);
		end
		pk_re = cau_pkg::pack_sat(ctl.neg_re, sel_re);
		pk_im = cau_pkg::pack_sat(ctl.neg_im, sel_im);
		if (ctl.dz) begin
			rsp_c.res_re = '0;
			rsp_c.res_im = '0;
			rsp_c.status = cau_pkg::ST_DZ;
		end else begin
			rsp_c.res_re = pk_re[cau_pkg::RW-1:0];
			rsp_c.res_im = pk_im[cau_pkg::RW-1:0];
			rsp_c.status = (pk_re[cau_pkg::RW] || pk_im[cau_pkg::RW]) ?
				cau_pkg::ST_SAT : cau_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rsp_s21 <= rsp_c;
		end
	end

	assign rsp_data = rsp_s21;

endmodule

### sv/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply and divide of Q8.8 operands to Q16.16.
// The unit accepts one beat per cycle while req_stall is low; each accepted beat passes
// through the stages in order: three front stages form products, sums and
// magnitudes, one stage sets up the division, sixteen stages of a restoring divider
// retire two quotient bits each, and a final stage saturates into the output register.
// Every operation, not only a divide, passes through the divider stages. A stall on
// the output side only holds the stages that are full; empty stages keep filling, so
// the input stalls only when the whole pipeline is occupied.
`include "assert_macros.svh"

module complex_arithmetic_unit (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_stall,
	input  cau_pkg::req_beat_t     req_data,
	output logic                   rsp_valid,
	input  logic                   rsp_stall,
	output cau_pkg::rsp_beat_t     rsp_data
);

	localparam int NST = cau_pkg::NST;
	localparam int ND  = cau_pkg::DIV_STAGES + 1;

	logic [NST-1:0]             vld_q;
	logic [NST-1:0]             adv;
	logic [cau_pkg::DW-1:0]     f_mag_re, f_mag_im, f_den;
	cau_pkg::ctl_t              f_ctl;
	cau_pkg::ctl_t              ctl_s [ND];
	logic [cau_pkg::QMW-1:0]    quo_re, quo_im;
	logic [cau_pkg::DW-1:0]     d_mag_re, d_mag_im;

	// A stage loads when it is empty or its successor loads.
	always_comb begin
		adv[NST-1] = !vld_q[NST-1] || !rsp_stall;
		for (int k = NST - 2; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= req_valid;
			end
			for (int k = 1; k < NST; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign req_stall = !adv[0];
	assign rsp_valid = vld_q[NST-1];

	cau_front u_front (
		.clk      (clk),
		.adv      (adv[2:0]),
		.req_data (req_data),
		.mag_re   (f_mag_re),
		.mag_im   (f_mag_im),
		.den      (f_den),
		.ctl      (f_ctl)
	);

	// Sideband follows the divider stages.
	always_ff @(posedge clk) begin
		if (adv[3]) begin
			ctl_s[0] <= f_ctl;
		end
		for (int k = 1; k < ND; k++) begin
			if (adv[3+k]) begin
				ctl_s[k] <= ctl_s[k-1];
			end
		end
	end

	cau_div u_div_re (
		.clk     (clk),
		.adv     (adv[3+ND-1:3]),
		.mag     (f_mag_re),
		.den     (f_den),
		.quo     (quo_re),
		.mag_out (d_mag_re)
	);

	cau_div u_div_im (
		.clk     (clk),
		.adv     (adv[3+ND-1:3]),
		.mag     (f_mag_im),
		.den     (f_den),
		.quo     (quo_im),
		.mag_out (d_mag_im)
	);

	cau_out u_out (
		.clk      (clk),
		.adv      (adv[NST-1]),
		.ctl      (ctl_s[ND-1]),
		.quo_re   (quo_re),
		.quo_im   (quo_im),
		.mag_re   (d_mag_re),
		.mag_im   (d_mag_im),
		.rsp_data (rsp_data)
	);

	// An accepted beat lands in the first stage.
	`CAU_ASSERT_NEXT(a_accept_lands, req_valid && !req_stall, vld_q[0], "accepted beat lost at entry")
	// The full stage before the output stage keeps its item when it cannot move.
	`CAU_ASSERT_NEXT(a_hold_item, vld_q[NST-2] && !adv[NST-2], vld_q[NST-2], "held item dropped")
	// A divide by zero reports zero parts.
	`CAU_ASSERT_NOW(a_dz_zero, rsp_valid && rsp_data.status == cau_pkg::ST_DZ, rsp_data.res_re == '0 && rsp_data.res_im == '0, "divide by zero with nonzero result")

endmodule
